// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/brs_pkg.sv -----
// ----------------------------------------------------------------------------
// brs_pkg
// Types, constants and the control store of the balanced range splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

  // Sizes
  localparam int unsigned MAX_SPLITS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_SPLITS);
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = DATA_W + CNT_W;
  localparam int unsigned DIVC_W     = $clog2(DATA_W + 1);
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned PC_W       = 4;
  localparam int unsigned MIN_PARTS  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PARTS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PART_SIZE = 1'b1;

  // Input word
  typedef struct packed {
    logic [DATA_W-1:0] start_offset;
    logic [DATA_W-1:0] population;
  } split_in_t;

  // Result word
  typedef struct packed {
    logic              no_split;
    logic [IDX_W-1:0]  part_index;
    logic [DATA_W-1:0] part_offset;
    logic [DATA_W-1:0] part_size;
    logic              last;
  } split_out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PROD,
    OP_COUNT_MAX,
    OP_DIV1_INIT,
    OP_DIV_STEP,
    OP_COUNT_QUO,
    OP_DIV2_INIT,
    OP_SPLIT_DONE,
    OP_EMIT,
    OP_NO_SPLIT
  } op_t;

  // Conditions that keep the sequencer on its current step
  typedef enum logic [2:0] {
    H_NONE,
    H_NO_IN,
    H_DIV,
    H_EMIT,
    H_OUT_BUSY
  } hold_t;

  // Branch conditions
  typedef enum logic [1:0] {
    J_NONE,
    J_ALWAYS,
    J_NOSPLIT,
    J_FULL
  } jump_t;

  typedef struct packed {
    op_t             op;
    hold_t           hold;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK    = 4'd1;
  localparam logic [PC_W-1:0] PC_COUNT    = 4'd2;
  localparam logic [PC_W-1:0] PC_D1_INIT  = 4'd3;
  localparam logic [PC_W-1:0] PC_D1_STEP  = 4'd4;
  localparam logic [PC_W-1:0] PC_D1_DONE  = 4'd5;
  localparam logic [PC_W-1:0] PC_D2_INIT  = 4'd6;
  localparam logic [PC_W-1:0] PC_D2_STEP  = 4'd7;
  localparam logic [PC_W-1:0] PC_D2_DONE  = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd9;
  localparam logic [PC_W-1:0] PC_NO_SPLIT = 4'd10;

  // Control store: hold wins over jump, else fall through to the next step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    case (pc)
      PC_IDLE:     uc = '{OP_LOAD,       H_NO_IN,    J_NONE,    PC_IDLE};
      PC_CHECK:    uc = '{OP_PROD,       H_NONE,     J_NOSPLIT, PC_NO_SPLIT};
      PC_COUNT:    uc = '{OP_COUNT_MAX,  H_NONE,     J_FULL,    PC_D2_INIT};
      PC_D1_INIT:  uc = '{OP_DIV1_INIT,  H_NONE,     J_NONE,    PC_IDLE};
      PC_D1_STEP:  uc = '{OP_DIV_STEP,   H_DIV,      J_NONE,    PC_IDLE};
      PC_D1_DONE:  uc = '{OP_COUNT_QUO,  H_NONE,     J_NONE,    PC_IDLE};
      PC_D2_INIT:  uc = '{OP_DIV2_INIT,  H_NONE,     J_NONE,    PC_IDLE};
      PC_D2_STEP:  uc = '{OP_DIV_STEP,   H_DIV,      J_NONE,    PC_IDLE};
      PC_D2_DONE:  uc = '{OP_SPLIT_DONE, H_NONE,     J_NONE,    PC_IDLE};
      PC_EMIT:     uc = '{OP_EMIT,       H_EMIT,     J_ALWAYS,  PC_IDLE};
      PC_NO_SPLIT: uc = '{OP_NO_SPLIT,   H_OUT_BUSY, J_ALWAYS,  PC_IDLE};
      default:     uc = '{OP_NOP,        H_NONE,     J_ALWAYS,  PC_IDLE};
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/balanced_range_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// balanced_range_splitter_unit
// Splits a work range into up to sixteen balanced segments, one word each.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry a range (start offset, population). One
//   range is taken at a time; in_stall is low only while the sequencer sits
//   on its idle step. For each range the block sends one or more words on
//   out_valid/out_stall/out_data, the final one flagged with last. A range
//   that cannot be split gives a single word with no_split set.
//   The first segment word waits on the divider: the maximum count is
//   used, or the count comes from population divided by the minimum
//   size; segments then follow one per cycle while out_stall is low. The
//   unsplit case answers without using the divider. The bit-serial divider
//   takes 4 steps for the count, 32 steps for segment size and remainder.
//   The output register holds its word while out_stall is high and the
//   sequencer waits on its emit step; nothing is dropped.
//   cfg_we writes max_parts (index 0) or min_part_size (index 1); write only
//   while idle. Synchronous reset returns the registers to 16 and 1, idles
//   the sequencer and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module balanced_range_splitter_unit
  import brs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // range input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire split_in_t            in_data,
  // segment output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output split_out_t                out_data,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [CNT_W-1:0]  max_parts_r;
  logic [DATA_W-1:0] min_part_size_r;

  // Sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uc;

  // Datapath registers
  logic [DATA_W-1:0] start_r, start_nxt;
  logic [DATA_W-1:0] pop_r, pop_nxt;
  logic [CNT_W-1:0]  maxp_r, maxp_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]  part_count_r, part_count_nxt;
  logic [DATA_W-1:0] base_size_r, base_size_nxt;
  logic [CNT_W-1:0]  extra_count_r, extra_count_nxt;
  logic [CNT_W-1:0]  next_index_r, next_index_nxt;
  logic [DATA_W-1:0] running_offset_r, running_offset_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] divisor_r, divisor_nxt;
  logic [DIVC_W-1:0] div_cnt_r, div_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  split_out_t        out_data_r, out_data_nxt;

  // Combinational helpers
  logic              in_fire;
  logic              out_free;
  logic [CNT_W-1:0]  maxp_c;
  logic              nosplit_c;
  logic              full_c;
  logic [DATA_W:0]   div_sh;
  logic              div_ge;
  logic [DATA_W:0]   div_diff;
  logic [DATA_W-1:0] seg_size_c;
  logic              seg_last_c;
  logic              hold_c;
  logic              jump_c;

  assign uc        = ucode_rom(pc_r);
  assign in_stall  = (uc.op != OP_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Count limit and split tests
  assign maxp_c    = (max_parts_r > CNT_W'(MAX_SPLITS)) ? CNT_W'(MAX_SPLITS) : max_parts_r;
  assign nosplit_c = (maxp_c < CNT_W'(MIN_PARTS)) || ({1'b0, pop_r} < {min_part_size_r, 1'b0});
  assign full_c    = ({{CNT_W{1'b0}}, pop_r} >= prod_r) || (min_part_size_r == '0);

  // One restoring division step
  assign div_sh   = {rem_r, quo_r[DATA_W-1]};
  assign div_diff = div_sh - {1'b0, divisor_r};
  assign div_ge   = (div_sh >= {1'b0, divisor_r});

  // Current segment
  assign seg_size_c = base_size_r + DATA_W'(next_index_r < extra_count_r);
  assign seg_last_c = (next_index_r == part_count_r - CNT_W'(1));

  // Sequencer conditions
  always_comb begin
    case (uc.hold)
      H_NONE:     hold_c = 1'b0;
      H_NO_IN:    hold_c = !in_fire;
      H_DIV:      hold_c = (div_cnt_r != DIVC_W'(1));
      H_EMIT:     hold_c = !(out_free && seg_last_c);
      H_OUT_BUSY: hold_c = !out_free;
      default:    hold_c = 1'b0;
    endcase
    case (uc.jump)
      J_NONE:    jump_c = 1'b0;
      J_ALWAYS:  jump_c = 1'b1;
      J_NOSPLIT: jump_c = nosplit_c;
      J_FULL:    jump_c = full_c;
      default:   jump_c = 1'b0;
    endcase
    if (hold_c) begin
      pc_nxt = pc_r;
    end else if (jump_c) begin
      pc_nxt = uc.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // Datapath driven by the control word
  always_comb begin
    start_nxt          = start_r;
    pop_nxt            = pop_r;
    maxp_nxt           = maxp_r;
    prod_nxt           = prod_r;
    part_count_nxt     = part_count_r;
    base_size_nxt      = base_size_r;
    extra_count_nxt    = extra_count_r;
    next_index_nxt     = next_index_r;
    running_offset_nxt = running_offset_r;
    rem_nxt            = rem_r;
    quo_nxt            = quo_r;
    divisor_nxt        = divisor_r;
    div_cnt_nxt        = div_cnt_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_data_nxt       = out_data_r;
    case (uc.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_fire) begin
          start_nxt = in_data.start_offset;
          pop_nxt   = in_data.population;
        end
      end
      OP_PROD: begin
        maxp_nxt = maxp_c;
        prod_nxt = PROD_W'(min_part_size_r) * PROD_W'(maxp_c);
      end
      OP_COUNT_MAX: begin
        part_count_nxt = maxp_r;
      end
      OP_DIV1_INIT: begin
        // quotient is below MAX_SPLITS, so only the low IDX_W bits need steps
        rem_nxt     = pop_r >> IDX_W;
        quo_nxt     = pop_r << (DATA_W - IDX_W);
        divisor_nxt = min_part_size_r;
        div_cnt_nxt = DIVC_W'(IDX_W);
      end
      OP_DIV_STEP: begin
        rem_nxt     = div_ge ? div_diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
        quo_nxt     = {quo_r[DATA_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r - DIVC_W'(1);
      end
      OP_COUNT_QUO: begin
        part_count_nxt = (quo_r[CNT_W-1:0] == '0) ? CNT_W'(1) : quo_r[CNT_W-1:0];
      end
      OP_DIV2_INIT: begin
        rem_nxt     = '0;
        quo_nxt     = pop_r;
        divisor_nxt = DATA_W'(part_count_r);
        div_cnt_nxt = DIVC_W'(DATA_W);
      end
      OP_SPLIT_DONE: begin
        base_size_nxt      = quo_r;
        extra_count_nxt    = rem_r[CNT_W-1:0];
        next_index_nxt     = '0;
        running_offset_nxt = start_r;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.no_split    = 1'b0;
          out_data_nxt.part_index  = next_index_r[IDX_W-1:0];
          out_data_nxt.part_offset = running_offset_r;
          out_data_nxt.part_size   = seg_size_c;
          out_data_nxt.last        = seg_last_c;
          running_offset_nxt       = running_offset_r + seg_size_c;
          next_index_nxt           = next_index_r + CNT_W'(1);
        end
      end
      OP_NO_SPLIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.no_split    = 1'b1;
          out_data_nxt.part_index  = '0;
          out_data_nxt.part_offset = '0;
          out_data_nxt.part_size   = '0;
          out_data_nxt.last        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r            <= PC_IDLE;
      out_valid_r     <= 1'b0;
      max_parts_r     <= CNT_W'(MAX_SPLITS);
      min_part_size_r <= DATA_W'(1);
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_PARTS:     max_parts_r     <= cfg_wdata[CNT_W-1:0];
          REG_MIN_PART_SIZE: min_part_size_r <= cfg_wdata[DATA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    start_r          <= start_nxt;
    pop_r            <= pop_nxt;
    maxp_r           <= maxp_nxt;
    prod_r           <= prod_nxt;
    part_count_r     <= part_count_nxt;
    base_size_r      <= base_size_nxt;
    extra_count_r    <= extra_count_nxt;
    next_index_r     <= next_index_nxt;
    running_offset_r <= running_offset_nxt;
    rem_r            <= rem_nxt;
    quo_r            <= quo_nxt;
    divisor_r        <= divisor_nxt;
    div_cnt_r        <= div_cnt_nxt;
    out_data_r       <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/brs_checker.sv -----
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the balanced range splitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module brs_checker
  import brs_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire split_out_t out_data
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // stalled word holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // unsplit word is alone and carries zero fields
  `ASSERT_IMPL(a_nosplit_clean, out_valid && out_data.no_split, out_data.last && out_data.part_index == '0 && out_data.part_offset == '0 && out_data.part_size == '0)

  // segments follow back to back, indexes and offsets chained
  `ASSERT_NEXT(a_seg_chain, out_fire && !out_data.last, out_valid && !out_data.no_split && out_data.part_index == $past(out_data.part_index) + IDX_W'(1) && out_data.part_offset == $past(out_data.part_offset) + $past(out_data.part_size))

  // one range at a time
  `ASSERT_NEXT(a_one_range, in_fire, in_stall)

endmodule

bind balanced_range_splitter_unit brs_checker u_brs_checker (.*);

`default_nettype wire
